// ----- rtl/core/tdpt_pkg.sv -----
// Shared constants and types for the trial-division prime test unit.
// No dependencies; imported by tdpt_serial_div, the top level and the testbench.
`default_nettype none

package tdpt_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
    localparam logic [1:0] VERDICT_PRIME     = 2'd1;
    localparam logic [1:0] VERDICT_NONE      = 2'd2;

    // status from the serial divider, valid in the cycle done is high
    typedef struct packed {
        logic             done;
        logic             rem_zero;
        logic [WIDTH-1:0] quotient;
    } div_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tdpt_serial_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle, WIDTH bits a division.
// Depends on tdpt_pkg for WIDTH, CNT_W and div_status_t.
`default_nettype none

module tdpt_serial_div
    import tdpt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output div_status_t           status
);

    logic             running_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] dvd_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // next partial remainder bit comes from the top of the dividend shift register
    assign trial = {rem_reg, dvd_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = !diff[WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (running_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (running_reg)
        begin
            dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
            rem_reg <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_reg <= {quo_reg[WIDTH-2:0], fits};
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);
    assign status.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/trial_division_prime_test_unit.sv -----
// Top level of the trial-division prime test: sequencer over trial divisors.
// Depends on tdpt_pkg and tdpt_serial_div.
//
//  channel   ports                 handshake
//  command   start, candidate      word taken when start && !busy
//  result    done, verdict         word shown for one cycle while done is high
//
// Candidates below two answer from idle without a division. Otherwise the bit-serial
// divider runs once per trial divisor d, for d = 2 up to floor(sqrt(n)) + 1.
// Reset clears the sequencer and the divider control; nothing is kept between words.
// busy falls in the cycle done is high, so a new start can land there.
`default_nettype none

module trial_division_prime_test_unit
    import tdpt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] candidate,
    output logic                  busy,
    output logic                  done,
    output logic [1:0]            verdict
);

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    state_t           state_reg;
    logic             done_reg;
    logic [1:0]       verdict_reg;
    logic             go_reg;
    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] d_reg;

    div_status_t      div_status;

    tdpt_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go_reg),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            verdict_reg <= VERDICT_NONE;
            go_reg      <= 1'b0;
            n_reg       <= '0;
            d_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            go_reg   <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (candidate < WIDTH'(2))
                        begin
                            verdict_reg <= VERDICT_NONE;
                            done_reg    <= 1'b1;
                        end
                        else
                        begin
                            n_reg     <= candidate;
                            d_reg     <= WIDTH'(2);
                            go_reg    <= 1'b1;
                            state_reg <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_status.done)
                    begin
                        // d > n / d means no divisor left below the square root
                        if (d_reg > div_status.quotient)
                        begin
                            verdict_reg <= VERDICT_PRIME;
                            done_reg    <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end
                        else if (div_status.rem_zero)
                        begin
                            verdict_reg <= VERDICT_COMPOSITE;
                            done_reg    <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            d_reg  <= d_reg + 1'b1;
                            go_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign verdict = verdict_reg;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for trial_division_prime_test_unit: drives candidate words,
// predicts each verdict by trial division and checks every done strobe against it.
// Depends on tdpt_pkg and the RTL of the unit; nothing else.
`default_nettype none

module testbench
    import tdpt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Timeout guard for the whole run, set well above the slowest correct run.
    localparam int unsigned CYCLE_LIMIT = 6000000;
    localparam int unsigned RANDOM_PER_PHASE = 26;
    localparam int unsigned DRAIN_CYCLES = 16;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic [WIDTH-1:0] candidate;
    logic             busy;
    logic             done;
    logic [1:0]       verdict;

    logic [WIDTH-1:0] candidate_q[$];   // words waiting to be issued
    logic [1:0]       verdict_q[$];     // verdicts owed by the unit, oldest first
    int unsigned      idle_pct;
    int unsigned      n_errors;
    int unsigned      n_cycles;

    trial_division_prime_test_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .candidate (candidate),
        .busy      (busy),
        .done      (done),
        .verdict   (verdict)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Trial division, stopping once d exceeds n / d.
    function automatic logic [1:0] classify_candidate(input logic [WIDTH-1:0] n);
        logic [WIDTH-1:0] d;
        if (n < 2)
            return VERDICT_NONE;
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return VERDICT_COMPOSITE;
        end
        return VERDICT_PRIME;
    endfunction

    // Mostly small words; the wide ones carry a small factor so they resolve quickly.
    function automatic logic [WIDTH-1:0] random_candidate();
        int unsigned      kind;
        int unsigned      k;
        logic [WIDTH-1:0] v;
        kind = $urandom_range(99);
        if (kind < 70)
            v = $urandom_range(4095);
        else if (kind < 90)
            v = $urandom_range(65535);
        else
        begin
            v = $urandom;
            k = $urandom_range(13, 2);
            v = v - (v % k);
        end
        return v;
    endfunction

    // Driver: holds a word on the port until taken, idling at random between words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            candidate <= '0;
        end
        else
        begin
            if (start && !busy)
                verdict_q.push_back(classify_candidate(candidate));
            if (!start || !busy)
            begin
                if (candidate_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start     <= 1'b1;
                    candidate <= candidate_q.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done strobe must match the oldest outstanding verdict.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual verdict %0d",
                         $time, verdict);
                n_errors++;
            end
            else
            begin
                if (verdict !== verdict_q[0])
                begin
                    $display("%0t: verdict mismatch: expected %0d, actual %0d",
                             $time, verdict_q[0], verdict);
                    n_errors++;
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned i;
        int unsigned phase_idle[3];

        phase_idle[0] = 62;
        phase_idle[1] = 6;
        phase_idle[2] = 0;
        n_errors = 0;
        n_cycles = 0;
        idle_pct = 0;
        rst_n    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: no-verdict values, two and three, squares of primes on the
        // square-root boundary, field extremes and a few slow prime/semiprime words.
        candidate_q.push_back(32'd0);
        candidate_q.push_back(32'd1);
        candidate_q.push_back(32'd2);
        candidate_q.push_back(32'd3);
        candidate_q.push_back(32'd4);
        candidate_q.push_back(32'd5);
        candidate_q.push_back(32'd6);
        candidate_q.push_back(32'd8);
        candidate_q.push_back(32'd9);
        candidate_q.push_back(32'd25);
        candidate_q.push_back(32'd49);
        candidate_q.push_back(32'd15);
        candidate_q.push_back(32'd97);
        candidate_q.push_back(32'd4093);
        candidate_q.push_back(32'd4099);
        candidate_q.push_back(32'd65521);
        candidate_q.push_back(32'd65537);
        candidate_q.push_back(32'd1048573);
        candidate_q.push_back(32'd16777207);
        candidate_q.push_back(32'hFFFF_FFFF);
        candidate_q.push_back(32'hFFFF_FFFE);
        candidate_q.push_back(32'h8000_0000);
        candidate_q.push_back(32'hAAAA_AAAA);
        candidate_q.push_back(32'h5555_5555);
        while (candidate_q.size() != 0)
            @(posedge clk);

        for (phase = 0; phase < 3; phase++)
        begin
            @(negedge clk);
            idle_pct = phase_idle[phase];
            for (i = 0; i < RANDOM_PER_PHASE; i++)
                candidate_q.push_back(random_candidate());
            while (candidate_q.size() != 0)
                @(posedge clk);
        end

        @(negedge clk);
        while (start !== 1'b0 || verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
